// ----- rtl/wavelet_decimating_line_filter_defines.svh -----
// Assertion macros shared by the line filter RTL.
`ifndef WAVELET_DECIMATING_LINE_FILTER_DEFINES_SVH
`define WAVELET_DECIMATING_LINE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define WDLF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define WDLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wdlf_pkg.sv -----
// Shared constants, types and helpers of the decimating line filter.
`default_nettype none

package wdlf_pkg;

  localparam int MAX_LINE      = 128;
  localparam int MAX_TAPS      = 8;
  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 16;
  localparam int ACC_W         = 35;
  localparam int POS_W         = 6;
  localparam int ADDR_W        = $clog2(MAX_LINE);
  localparam int LEN_W         = ADDR_W + 1;
  localparam int TAP_W         = $clog2(MAX_TAPS);
  localparam int TAPCNT_W      = 4;
  localparam int OFF_W         = 5;
  localparam int IDX_W         = 10;
  localparam int PROD_W        = SAMPLE_W + COEF_W;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int TAPS_PER_WORD = CFG_W / COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRAP_MODE    = 3'd0,
    REG_DUAL_DIR     = 3'd1,
    REG_TAP_COUNT    = 3'd2,
    REG_START_OFFSET = 3'd3,
    REG_LINE_LENGTH  = 3'd4,
    REG_COEFFS_LOW   = 3'd5,
    REG_COEFFS_HIGH  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN
  } seq_state_e;

  // Live configuration, line length already clamped to an even legal value.
  typedef struct packed {
    logic                 wrap;
    logic                 dual;
    logic [TAPCNT_W-1:0]  taps;
    logic [OFF_W-1:0]     offset;
    logic [LEN_W-1:0]     len;
    logic [CFG_W-1:0]     coef_lo;
    logic [CFG_W-1:0]     coef_hi;
  } cfg_t;

  // One tap handed from the sequencer to the MAC pipeline.
  typedef struct packed {
    logic              valid;
    logic              use_tap;
    logic              first;
    logic              last;
    logic [POS_W-1:0]  pos;
    logic              eol;
    logic [COEF_W-1:0] coef;
  } issue_t;

  function automatic logic [COEF_W-1:0] tap_coef(input logic [CFG_W-1:0] lo,
                                                 input logic [CFG_W-1:0] hi,
                                                 input logic [TAP_W-1:0] k);
    logic [CFG_W-1:0] word;
    int               lane;
    word = (int'(k) >= TAPS_PER_WORD) ? hi : lo;
    lane = int'(k) % TAPS_PER_WORD;
    return word[lane*COEF_W +: COEF_W];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wavelet_decimating_line_filter.sv -----
// Top level of the decimating wavelet line filter.
//
// Usage: drive sample_i with start_i high; the sample is taken at a rising edge where
// busy_o is low, one sample per cycle while the line fills. The sample that completes
// the line (line_length, rounded down to even and clamped to 2..128) raises busy_o.
// The block then folds the first filter index into the line (up to eight adds or
// subtracts, then one step to load the index), and issues one tap per cycle to a
// single 16x16 multiplier and 35-bit accumulator: max(tap_count,1) taps per output
// (tap_count saturates at 8), line_length/2 outputs.
// Each result beat shows for exactly one cycle on value_o / position_o /
// last_of_line_o with out_valid_o high; a beat passes the s1, s2 and result registers
// after the last tap of its output issues.
// No new line is taken while the single MAC unit still holds taps of the last one.
// The receiver cannot stall: every result beat is taken in the cycle it shows.
// Reset clears the fill count, the sequencer and the output strobe, and restores the
// register defaults (periodic wrap, two taps, offset 0, 128 samples, zero coefficients).
// Write registers through cfg_we_i / cfg_idx_i / cfg_data_i only while busy_o is low.
`default_nettype none

module wavelet_decimating_line_filter import wdlf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  output logic                       out_valid_o,
  output logic signed [ACC_W-1:0]    value_o,
  output logic [POS_W-1:0]           position_o,
  output logic                       last_of_line_o
);

  // Configuration registers.
  logic                 wrap_q;
  logic                 dual_q;
  logic [TAPCNT_W-1:0]  taps_q;
  logic [OFF_W-1:0]     offset_q;
  logic [LEN_W-1:0]     line_len_q;
  logic [CFG_W-1:0]     coef_lo_q;
  logic [CFG_W-1:0]     coef_hi_q;

  logic [LEN_W-1:0]     len_even;
  logic [LEN_W-1:0]     len_eff;
  cfg_t                 cfg;

  logic                 mac_busy;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0]  rdata;
  issue_t               issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q     <= 1'b1;
      dual_q     <= 1'b0;
      taps_q     <= TAPCNT_W'(2);
      offset_q   <= '0;
      line_len_q <= LEN_W'(MAX_LINE);
      coef_lo_q  <= '0;
      coef_hi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WRAP_MODE:    wrap_q     <= cfg_data_i[0];
        REG_DUAL_DIR:     dual_q     <= cfg_data_i[0];
        REG_TAP_COUNT:    taps_q     <= cfg_data_i[TAPCNT_W-1:0];
        REG_START_OFFSET: offset_q   <= cfg_data_i[OFF_W-1:0];
        REG_LINE_LENGTH:  line_len_q <= cfg_data_i[LEN_W-1:0];
        REG_COEFFS_LOW:   coef_lo_q  <= cfg_data_i;
        REG_COEFFS_HIGH:  coef_hi_q  <= cfg_data_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Drop bit 0 of the length, then clamp into 2..MAX_LINE.
  assign len_even = {line_len_q[LEN_W-1:1], 1'b0};
  always_comb begin
    if (len_even < LEN_W'(2)) begin
      len_eff = LEN_W'(2);
    end else if (len_even > LEN_W'(MAX_LINE)) begin
      len_eff = LEN_W'(MAX_LINE);
    end else begin
      len_eff = len_even;
    end
  end

  always_comb begin
    cfg.wrap    = wrap_q;
    cfg.dual    = dual_q;
    cfg.taps    = taps_q;
    cfg.offset  = offset_q;
    cfg.len     = len_eff;
    cfg.coef_lo = coef_lo_q;
    cfg.coef_hi = coef_hi_q;
  end

  // Fill the store, wrap indexes and issue taps.
  wdlf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cfg_i      (cfg),
    .mac_busy_i (mac_busy),
    .busy_o     (busy_o),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .issue_o    (issue)
  );

  // Hold one line of samples.
  wdlf_store u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (sample_i),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Multiply, accumulate and present each result beat.
  wdlf_mac u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .issue_i        (issue),
    .rdata_i        (rdata),
    .busy_o         (mac_busy),
    .out_valid_o    (out_valid_o),
    .value_o        (value_o),
    .position_o     (position_o),
    .last_of_line_o (last_of_line_o)
  );

endmodule

`default_nettype wire

// ----- rtl/wdlf_store.sv -----
// Line store: one write port, one registered read port.
`default_nettype none

module wdlf_store import wdlf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [ADDR_W-1:0]   waddr_i,
  input  wire logic [SAMPLE_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]   raddr_i,
  output logic      [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem_q [MAX_LINE];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/wdlf_seq.sv -----
// Sequencer: line fill, index wrap and tap issue to the MAC pipeline.
`default_nettype none

module wdlf_seq import wdlf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire cfg_t              cfg_i,
  input  wire logic              mac_busy_i,
  output logic                   busy_o,
  output logic                   wr_en_o,
  output logic [ADDR_W-1:0]      wr_addr_o,
  output logic [ADDR_W-1:0]      rd_addr_o,
  output issue_t                 issue_o
);

  `include "wavelet_decimating_line_filter_defines.svh"

  seq_state_e                state_q, state_d;
  logic [LEN_W-1:0]          fill_q, fill_d;
  logic [POS_W-1:0]          j_q, j_d;
  logic [TAP_W-1:0]          k_q, k_d;
  logic [ADDR_W-1:0]         wk_q, wk_d;
  logic [ADDR_W-1:0]         wbase_q, wbase_d;
  logic signed [IDX_W-1:0]   raw_q, raw_d;
  logic signed [IDX_W-1:0]   rawbase_q, rawbase_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic [TAP_W-1:0]          klast_q, klast_d;
  logic                      dual_q, dual_d;
  logic                      wrap_q, wrap_d;
  logic                      tapen_q, tapen_d;

  logic                      accept;
  logic [LEN_W-1:0]          fill_inc;
  logic signed [IDX_W-1:0]   off_ext;
  logic signed [IDX_W-1:0]   base_init;
  logic signed [IDX_W-1:0]   len_s;
  logic [LEN_W-2:0]          half_m1;
  logic [LEN_W-1:0]          len_m1;
  logic                      eol;
  logic                      in_range;
  logic                      wk_in_len;
  logic                      tap_done;
  logic [LEN_W-1:0]          wb_sum;
  logic [LEN_W-1:0]          wb_wrap;
  logic [ADDR_W-1:0]         wk_step;
  logic [TAPCNT_W-1:0]       taps_sat;

  assign busy_o   = (state_q != ST_IDLE) | mac_busy_i;
  assign accept   = start_i & ~busy_o;
  assign fill_inc = fill_q + LEN_W'(1);

  assign off_ext   = {{(IDX_W-OFF_W){cfg_i.offset[OFF_W-1]}}, cfg_i.offset};
  assign base_init = cfg_i.dual ? (IDX_W'(1) + off_ext) : (IDX_W'(1) - off_ext);

  assign len_s     = $signed({{(IDX_W-LEN_W){1'b0}}, len_q});
  assign half_m1   = len_q[LEN_W-1:1] - (LEN_W-1)'(1);
  assign len_m1    = len_q - LEN_W'(1);
  assign eol       = ({1'b0, j_q} == half_m1);
  assign in_range  = ~raw_q[IDX_W-1] & (raw_q < len_s);
  assign wk_in_len = ({1'b0, wk_q} < len_q);
  assign tap_done  = (k_q == klast_q);

  // Advance the wrapped base by two; one subtract is enough since len >= 2.
  assign wb_sum  = {1'b0, wbase_q} + LEN_W'(2);
  assign wb_wrap = (wb_sum >= len_q) ? (wb_sum - len_q) : wb_sum;

  always_comb begin
    if (dual_q) begin
      wk_step = ({1'b0, wk_q} == len_m1) ? '0 : (wk_q + ADDR_W'(1));
    end else begin
      wk_step = (wk_q == '0) ? len_m1[ADDR_W-1:0] : (wk_q - ADDR_W'(1));
    end
  end

  assign taps_sat = (cfg_i.taps > TAPCNT_W'(MAX_TAPS)) ? TAPCNT_W'(MAX_TAPS) : cfg_i.taps;

  assign wr_en_o   = accept;
  assign wr_addr_o = fill_q[ADDR_W-1:0];
  assign rd_addr_o = wk_q;

  always_comb begin
    issue_o.valid   = (state_q == ST_RUN);
    issue_o.use_tap = tapen_q & (wrap_q | in_range);
    issue_o.first   = (k_q == '0);
    issue_o.last    = tap_done;
    issue_o.pos     = j_q;
    issue_o.eol     = eol;
    issue_o.coef    = tap_coef(cfg_i.coef_lo, cfg_i.coef_hi, k_q);
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    j_d       = j_q;
    k_d       = k_q;
    wk_d      = wk_q;
    wbase_d   = wbase_q;
    raw_d     = raw_q;
    rawbase_d = rawbase_q;
    len_d     = len_q;
    klast_d   = klast_q;
    dual_d    = dual_q;
    wrap_d    = wrap_q;
    tapen_d   = tapen_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          fill_d = fill_inc;
          if (fill_inc >= cfg_i.len) begin
            fill_d    = '0;
            state_d   = ST_PREP;
            len_d     = cfg_i.len;
            dual_d    = cfg_i.dual;
            wrap_d    = cfg_i.wrap;
            tapen_d   = (cfg_i.taps != '0);
            klast_d   = (taps_sat == '0) ? '0 : TAP_W'(taps_sat - TAPCNT_W'(1));
            raw_d     = base_init;
            rawbase_d = base_init;
          end
        end
      end
      ST_PREP: begin
        // Fold the first index into the line, one add or subtract a cycle.
        if (raw_q[IDX_W-1]) begin
          raw_d = raw_q + len_s;
        end else if (raw_q >= len_s) begin
          raw_d = raw_q - len_s;
        end else begin
          wk_d    = raw_q[ADDR_W-1:0];
          wbase_d = raw_q[ADDR_W-1:0];
          raw_d   = rawbase_q;
          j_d     = '0;
          k_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tap_done) begin
          k_d = '0;
          if (eol) begin
            state_d = ST_IDLE;
          end else begin
            j_d       = j_q + POS_W'(1);
            wbase_d   = wb_wrap[ADDR_W-1:0];
            wk_d      = wb_wrap[ADDR_W-1:0];
            rawbase_d = rawbase_q + IDX_W'(2);
            raw_d     = rawbase_q + IDX_W'(2);
          end
        end else begin
          k_d   = k_q + TAP_W'(1);
          wk_d  = wk_step;
          raw_d = dual_q ? (raw_q + IDX_W'(1)) : (raw_q - IDX_W'(1));
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q       <= j_d;
    k_q       <= k_d;
    wk_q      <= wk_d;
    wbase_q   <= wbase_d;
    raw_q     <= raw_d;
    rawbase_q <= rawbase_d;
    len_q     <= len_d;
    klast_q   <= klast_d;
    dual_q    <= dual_d;
    wrap_q    <= wrap_d;
    tapen_q   <= tapen_d;
  end

  `WDLF_ASSERT_NOW(a_wk_inside_line, state_q == ST_RUN, wk_in_len, "wrapped index outside line")
  `WDLF_ASSERT_NOW(a_wk_tracks_raw, (state_q == ST_RUN) && in_range, wk_q == raw_q[ADDR_W-1:0], "wrapped index lost track of raw index")
  `WDLF_ASSERT_NEXT(a_line_ends, (state_q == ST_RUN) && tap_done && eol, state_q == ST_IDLE, "sequencer ran past last output")

endmodule

`default_nettype wire

// ----- rtl/wdlf_mac.sv -----
// Shared multiply-accumulate pipeline and result register.
`default_nettype none

module wdlf_mac import wdlf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire issue_t               issue_i,
  input  wire logic [SAMPLE_W-1:0]  rdata_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  output logic signed [ACC_W-1:0]   value_o,
  output logic [POS_W-1:0]          position_o,
  output logic                      last_of_line_o
);

  issue_t                    s1_q;
  logic                      s1_valid_q;
  logic                      s2_valid_q;
  logic                      s2_first_q;
  logic                      s2_last_q;
  logic [POS_W-1:0]          s2_pos_q;
  logic                      s2_eol_q;
  logic signed [PROD_W-1:0]  prod_full;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic                      out_valid_q;
  logic signed [ACC_W-1:0]   value_q;
  logic [POS_W-1:0]          pos_q;
  logic                      eol_q;

  // Signed 16x16 product, formed apart from the tap select so both factors extend by sign.
  assign prod_full = $signed(s1_q.coef) * $signed(rdata_i);

  // Skipped taps contribute zero.
  assign prod_d = s1_q.use_tap ? prod_full : '0;

  // Restart the sum on the first tap of each output.
  assign acc_d = (s2_first_q ? '0 : acc_q) + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= issue_i.valid;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q & s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q       <= issue_i;
    prod_q     <= prod_d;
    s2_first_q <= s1_q.first;
    s2_last_q  <= s1_q.last;
    s2_pos_q   <= s1_q.pos;
    s2_eol_q   <= s1_q.eol;
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
    if (s2_valid_q && s2_last_q) begin
      value_q <= acc_d;
      pos_q   <= s2_pos_q;
      eol_q   <= s2_eol_q;
    end
  end

  assign busy_o         = s1_valid_q | s2_valid_q;
  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign position_o     = pos_q;
  assign last_of_line_o = eol_q;

endmodule

`default_nettype wire
